### sv/pic_pkg.sv
// types and command codes shared by the priority interrupt controller
package pic_pkg;

    localparam logic [1:0] CMD_POST = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TAKE = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [3:0] level;
        logic [7:0] vector;
        logic [3:0] threshold;
    } pic_in_t;

    typedef struct packed {
        logic       accepted;
        logic       found;
        logic [3:0] taken_level;
        logic [7:0] taken_vector;
        logic       pending_flag;
    } pic_out_t;

endpackage

### sv/priority_interrupt_controller.sv
// priority interrupt controller top level
//
// the s_ channel carries one command word: post a vector at a level,
// acknowledge a level, or take the highest occupied level at or above
// the threshold. every command word yields exactly one result word on
// the m_ channel, in order.
// a word accepted on s_ lands in an input register; once the output
// register is free, the command is decoded against the per-level
// occupied bits and the pending flag, state is updated and the result
// is loaded into the output register. throughput is one word per cycle
// while m_ready stays high, set by the single pass from the input
// register through the level priority pick to the output register.
// the vector slots sit in a memory with one write port (post) and one
// read port (selected level); the read data is the registered taken_vector.
// when m_ready is low the output register holds its word and the input
// register still takes one more word; s_ready drops once both are full.
// reset (aresetn low, synchronous) empties every level through the
// occupied bits, clears the pending flag and both valid flags at once;
// no clearing pass is needed.
module priority_interrupt_controller
    import pic_pkg::*;
#(
    parameter int LEVELS       = 16,
    parameter int VECTOR_COUNT = 64
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pic_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pic_out_t m_data
);

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    logic              in_valid_reg;
    pic_in_t           in_data_reg;
    logic              out_valid_reg;
    pic_out_t          out_data_reg;
    logic [7:0]        vec_rd_reg;
    logic [LEVELS-1:0] occ_reg;
    logic [LEVELS-1:0] occ_next;
    logic              pend_reg;
    logic              pend_next;
    logic [7:0]        vec_mem [LEVELS];

    logic              advance;
    logic              lvl_ok;
    logic              vec_ok;
    logic [LW-1:0]     lvl_idx;
    logic              hit;
    logic [LW-1:0]     sel_idx;
    logic              wr_en;
    pic_out_t          res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign lvl_ok  = int'(in_data_reg.level) < LEVELS;
    assign vec_ok  = int'(in_data_reg.vector) < VECTOR_COUNT;
    assign lvl_idx = LW'(in_data_reg.level);

    // highest occupied level at or above the threshold
    always_comb begin
        hit     = 1'b0;
        sel_idx = '0;
        for (int i = 0; i < LEVELS; i++) begin
            if (occ_reg[i] && (i >= int'(in_data_reg.threshold))) begin
                hit     = 1'b1;
                sel_idx = LW'(i);
            end
        end
    end

    always_comb begin
        occ_next  = occ_reg;
        pend_next = pend_reg;
        wr_en     = 1'b0;
        res       = '0;
        unique case (in_data_reg.command)
            CMD_POST: begin
                if (lvl_ok && !occ_reg[lvl_idx] && vec_ok) begin
                    occ_next[lvl_idx] = |in_data_reg.vector;
                    pend_next         = 1'b1;
                    wr_en             = 1'b1;
                    res.accepted      = 1'b1;
                end
            end
            CMD_ACK: begin
                if (lvl_ok) begin
                    occ_next[lvl_idx] = 1'b0;
                    if (occ_next == '0) begin
                        pend_next = 1'b0;
                    end
                end
            end
            CMD_TAKE: begin
                if (pend_reg) begin
                    if (hit) begin
                        occ_next[sel_idx] = 1'b0;
                        res.found         = 1'b1;
                        res.taken_level   = 4'(sel_idx);
                        if (occ_next == '0) begin
                            pend_next = 1'b0;
                        end
                    end else begin
                        pend_next = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
        res.pending_flag = pend_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
            pend_reg      <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                occ_reg       <= occ_next;
                pend_reg      <= pend_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= res;
        end
    end

    // vector slots
    always_ff @(posedge aclk) begin
        if (advance && wr_en) begin
            vec_mem[lvl_idx] <= in_data_reg.vector;
        end
        if (advance) begin
            vec_rd_reg <= vec_mem[sel_idx];
        end
    end

    assign m_valid = out_valid_reg;

    always_comb begin
        m_data              = out_data_reg;
        m_data.taken_vector = out_data_reg.found ? vec_rd_reg : 8'd0;
    end

endmodule

### sv/pic_checker.sv
// port checker for the priority interrupt controller and its bind
module pic_checker
    import pic_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input pic_out_t m_data
);

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // a take that finds a level always carries a nonzero vector
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.found |-> m_data.taken_vector != 8'd0)
        else $error("found with empty vector");

    // an accepted post leaves the pending flag set and is never a take
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> m_data.pending_flag && !m_data.found)
        else $error("accepted post without pending flag");

    // no take result fields without a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.found |->
            m_data.taken_level == 4'd0 && m_data.taken_vector == 8'd0)
        else $error("take fields set without a hit");

endmodule

bind priority_interrupt_controller pic_checker u_pic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
